### hw/rtl/mono_page_glyph_blitter_defines.svh
// assertion macros for the glyph blitter checker
`ifndef MONO_PAGE_GLYPH_BLITTER_DEFINES_SVH
`define MONO_PAGE_GLYPH_BLITTER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define MPGB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MPGB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/mpgb_pkg.sv
// shared constants, codes and merge functions for the glyph blitter
`default_nettype none

package mpgb_pkg;

	// framebuffer and font store geometry
	localparam int MAX_COLUMNS = 128;
	localparam int PAGES       = 8;
	localparam int FONT_BYTES  = 4096;
	localparam int FB_SIZE     = MAX_COLUMNS * PAGES;
	localparam int FB_AW       = $clog2(FB_SIZE);
	localparam int ROW_W       = FB_AW + 1;
	localparam int FA_W        = $clog2(FONT_BYTES);
	localparam int GLYPH_MAX   = 16;
	localparam int COL_W       = $clog2(GLYPH_MAX);

	// command codes
	typedef enum logic [2:0] {
		OP_FONT = 3'd0,
		OP_SET  = 3'd1,
		OP_GET  = 3'd2,
		OP_DRAW = 3'd3,
		OP_READ = 3'd4
	} op_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_LINE_WIDTH   = 3'd0,
		REG_GLYPH_WIDTH  = 3'd1,
		REG_GLYPH_ROWS   = 3'd2,
		REG_GLYPH_HEIGHT = 3'd3,
		REG_GLYPH_BYTES  = 3'd4
	} cfg_reg_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FONT,
		ST_PIX_RD,
		ST_PIX_WR,
		ST_G_RD0,
		ST_G_RD1,
		ST_G_WR,
		ST_DONE
	} state_t;

	// shifted column bits for one colour mode; for black on black the result is an and-mask
	function automatic logic [15:0] glyph_bits(input logic [15:0] g, input logic [15:0] mask,
			input logic fc, input logic bc, input logic [2:0] s);
		logic [15:0] src;
		logic [15:0] sh;
		case ({fc, bc})
			2'b10: src = g;
			2'b01: src = ~g & mask;
			2'b11: src = mask;
			default: src = mask;
		endcase
		sh = src << s;
		if (!fc && !bc) begin
			glyph_bits = ~sh;
		end else begin
			glyph_bits = sh;
		end
	endfunction

	// merge one byte into a framebuffer byte
	function automatic logic [7:0] merge_byte(input logic [7:0] old, input logic [7:0] v,
			input logic and_mode);
		if (and_mode) begin
			merge_byte = old & v;
		end else begin
			merge_byte = old | v;
		end
	endfunction

endpackage

`default_nettype wire

### hw/rtl/mpgb_ram.sv
// generic simple dual-port ram, one write port and one registered read port
`default_nettype none

module mpgb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### hw/rtl/mono_page_glyph_blitter.sv
// Monochrome page framebuffer with font store and glyph drawing.
// Input channel in_valid/in_ready carries one command per transaction: load a font
// byte, set a pixel, get a pixel, draw a glyph or read a framebuffer byte.
// Output channel out_valid/out_ready returns exactly one result (read_data, drawn)
// per command, in order. Configuration is written through cfg_we/cfg_index/cfg_data
// with no wait; the user must write it only while no command is in flight, and the
// block does not enforce this. A font load writes the font store, a pixel or byte
// access reads the framebuffer and, for a set, writes it back, a glyph draw works
// column by column, and a skipped draw or unused code goes straight to the result.
// One command is worked at a time; the next is taken the cycle after the result is
// written to the output register. Glyph draw speed is set by the single frame
// memory ports: each column reads and rewrites two framebuffer bytes.
// After reset the framebuffer is cleared one byte a cycle over its 1024 bytes, during
// which in_ready is low; configuration registers return to their defaults.
// The result register holds while out_ready is low; a new command is still taken
// during that stall, and it waits in its final state until the register frees.
`default_nettype none

module mono_page_glyph_blitter
	import mpgb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	// configuration
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	// command channel
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] op,
	input  wire logic [6:0] x_pos,
	input  wire logic [5:0] y_pos,
	input  wire logic       fore_color,
	input  wire logic       back_color,
	input  wire logic [7:0] char_code,
	input  wire logic [11:0] font_addr,
	input  wire logic [7:0] font_byte,
	input  wire logic [9:0] fb_addr,
	// result channel
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      read_data,
	output logic            drawn
);

	state_t state_q, state_d;

	// configuration registers
	logic [7:0] line_width_q;
	logic [4:0] glyph_width_q;
	logic [1:0] glyph_rows_q;
	logic [4:0] glyph_height_q;
	logic [5:0] glyph_bytes_q;

	// control registers
	logic [FB_AW-1:0] clr_q;
	logic [COL_W-1:0] c_q;
	logic             out_valid_q;

	// command and result payload registers
	logic [2:0]       op_q;
	logic [6:0]       x_q;
	logic [5:0]       y_q;
	logic             fc_q;
	logic             bc_q;
	logic [FA_W-1:0]  fa_q;
	logic [7:0]       fbyte_q;
	logic [9:0]       fb_q;
	logic [ROW_W-1:0] rowbase_q;
	logic [ROW_W-1:0] rowbelow_q;
	logic [FA_W-1:0]  base_q;
	logic [7:0]       glo_q;
	logic [7:0]       rd_res_q;
	logic             drawn_res_q;
	logic [7:0]       read_data_q;
	logic             drawn_q;

	// memory ports
	logic             fb_we;
	logic [FB_AW-1:0] fb_waddr;
	logic [7:0]       fb_wdata;
	logic [FB_AW-1:0] fb_raddr;
	logic [7:0]       fb_rdata;
	logic             font_we;
	logic [FA_W-1:0]  font_waddr;
	logic [FA_W-1:0]  font_raddr;
	logic [7:0]       font_rdata;

	logic out_load;
	logic accept;

	// effective geometry from the registers
	logic [7:0]       w_eff;
	logic [4:0]       gw_eff;
	logic [4:0]       gh_eff;
	logic             rows2;
	logic [16:0]      mask17;
	logic [15:0]      mask;
	logic [2:0]       page_q;
	logic [2:0]       s_q;
	logic             and_mode;

	// column addressing
	logic [COL_W-1:0] rd_col;
	logic             last_col;
	logic [7:0]       colx_rd;
	logic [7:0]       colx_wr;
	logic [ROW_W-1:0] addr_a_rd;
	logic [ROW_W-1:0] addr_a_wr;
	logic [ROW_W-1:0] addr_b_wr;
	logic             valid_a;
	logic             valid_b;
	logic [FA_W-1:0]  fa_r0;
	logic [FA_W-1:0]  fa_r1;

	// pixel and byte access
	logic [ROW_W-1:0] pix_addr;
	logic             pix_ok;
	logic             fb_ok;
	logic             font_ok;
	logic [7:0]       bit_mask;

	// merged bytes
	logic [7:0]  g_hi;
	logic [15:0] bits_lo;
	logic [15:0] bits_hi;
	logic [7:0]  new_a;
	logic [7:0]  new_b;

	assign accept = in_valid && in_ready;

	assign w_eff  = (32'(line_width_q) > MAX_COLUMNS) ? 8'(MAX_COLUMNS) : line_width_q;
	assign gw_eff = (32'(glyph_width_q) > GLYPH_MAX) ? 5'(GLYPH_MAX) : glyph_width_q;
	assign gh_eff = (32'(glyph_height_q) > GLYPH_MAX) ? 5'(GLYPH_MAX) : glyph_height_q;
	assign rows2  = glyph_rows_q[1];
	assign mask17 = (17'd1 << gh_eff) - 17'd1;
	assign mask   = mask17[15:0];
	assign page_q = y_q[5:3];
	assign s_q    = y_q[2:0];
	assign and_mode = !fc_q && !bc_q;

	// reads run one column ahead while the page-below byte is written
	assign rd_col    = (state_q == ST_G_WR) ? c_q + COL_W'(1) : c_q;
	assign last_col  = ({1'b0, c_q} == gw_eff - 5'd1);
	assign colx_rd   = 8'(x_q) + 8'(rd_col);
	assign colx_wr   = 8'(x_q) + 8'(c_q);
	assign addr_a_rd = rowbase_q + ROW_W'(colx_rd);
	assign addr_a_wr = rowbase_q + ROW_W'(colx_wr);
	assign addr_b_wr = rowbelow_q + ROW_W'(colx_wr);
	assign valid_a   = (colx_wr < w_eff) && (32'(page_q) < PAGES) &&
		(32'(addr_a_wr) < FB_SIZE);
	assign valid_b   = (colx_wr < w_eff) && (32'(page_q) + 1 < PAGES) &&
		(32'(addr_b_wr) < FB_SIZE);
	assign fa_r0     = base_q + FA_W'(rd_col);
	assign fa_r1     = base_q + FA_W'(gw_eff) + FA_W'(c_q);

	// pixel and byte address checks
	assign pix_addr = rowbase_q + ROW_W'(x_q);
	assign pix_ok   = ({1'b0, x_q} < w_eff) && (32'(page_q) < PAGES) &&
		(32'(pix_addr) < FB_SIZE);
	assign fb_ok    = 32'(fb_q) < FB_SIZE;
	assign font_ok  = 32'(fa_q) < FONT_BYTES;
	assign bit_mask = 8'd1 << s_q;

	// column merge: low byte needs only the first font byte
	assign g_hi    = rows2 ? font_rdata : 8'd0;
	assign bits_lo = glyph_bits({8'd0, font_rdata}, mask, fc_q, bc_q, s_q);
	assign bits_hi = glyph_bits({g_hi, glo_q}, mask, fc_q, bc_q, s_q);
	assign new_a   = merge_byte(fb_rdata, bits_lo[7:0], and_mode);
	assign new_b   = merge_byte(fb_rdata, bits_hi[15:8], and_mode);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == FB_AW'(FB_SIZE - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					case (op_t'(op))
						OP_FONT: state_d = ST_FONT;
						OP_SET, OP_GET, OP_READ: state_d = ST_PIX_RD;
						OP_DRAW: begin
							if ((char_code == 8'd0 && !back_color) || gw_eff == 5'd0) begin
								state_d = ST_DONE;
							end else begin
								state_d = ST_G_RD0;
							end
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_FONT:   state_d = ST_DONE;
			ST_PIX_RD: state_d = ST_PIX_WR;
			ST_PIX_WR: state_d = ST_DONE;
			ST_G_RD0:  state_d = ST_G_RD1;
			ST_G_RD1:  state_d = ST_G_WR;
			ST_G_WR: begin
				if (last_col) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_G_RD1;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// memory controls and handshake outputs
	always_comb begin
		in_ready   = 1'b0;
		out_load   = 1'b0;
		fb_we      = 1'b0;
		fb_waddr   = '0;
		fb_wdata   = '0;
		fb_raddr   = '0;
		font_we    = 1'b0;
		font_waddr = fa_q;
		font_raddr = '0;
		case (state_q)
			ST_CLEAR: begin
				fb_we    = 1'b1;
				fb_waddr = clr_q;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_FONT: begin
				font_we = font_ok;
			end
			ST_PIX_RD: begin
				if (op_q == OP_READ) begin
					fb_raddr = fb_q;
				end else begin
					fb_raddr = pix_addr[FB_AW-1:0];
				end
			end
			ST_PIX_WR: begin
				fb_we    = (op_q == OP_SET) && pix_ok;
				fb_waddr = pix_addr[FB_AW-1:0];
				fb_wdata = fc_q ? (fb_rdata | bit_mask) : (fb_rdata & ~bit_mask);
			end
			ST_G_RD0: begin
				font_raddr = fa_r0;
				fb_raddr   = addr_a_rd[FB_AW-1:0];
			end
			ST_G_RD1: begin
				font_raddr = fa_r1;
				fb_raddr   = addr_b_wr[FB_AW-1:0];
				fb_we      = valid_a;
				fb_waddr   = addr_a_wr[FB_AW-1:0];
				fb_wdata   = new_a;
			end
			ST_G_WR: begin
				font_raddr = fa_r0;
				fb_raddr   = addr_a_rd[FB_AW-1:0];
				fb_we      = valid_b;
				fb_waddr   = addr_b_wr[FB_AW-1:0];
				fb_wdata   = new_b;
			end
			ST_DONE: begin
				out_load = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// control registers and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			c_q            <= '0;
			out_valid_q    <= 1'b0;
			line_width_q   <= 8'd128;
			glyph_width_q  <= 5'd8;
			glyph_rows_q   <= 2'd1;
			glyph_height_q <= 5'd8;
			glyph_bytes_q  <= 6'd8;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + FB_AW'(1);
			end
			if (accept) begin
				c_q <= '0;
			end else if (state_q == ST_G_WR && !last_col) begin
				c_q <= c_q + COL_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_LINE_WIDTH:   line_width_q   <= cfg_data;
					REG_GLYPH_WIDTH:  glyph_width_q  <= cfg_data[4:0];
					REG_GLYPH_ROWS:   glyph_rows_q   <= cfg_data[1:0];
					REG_GLYPH_HEIGHT: glyph_height_q <= cfg_data[4:0];
					REG_GLYPH_BYTES:  glyph_bytes_q  <= cfg_data[5:0];
					default: ;
				endcase
			end
		end
	end

	// command capture, per-command results and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= op;
			x_q         <= x_pos;
			y_q         <= y_pos;
			fc_q        <= fore_color;
			bc_q        <= back_color;
			fa_q        <= font_addr;
			fbyte_q     <= font_byte;
			fb_q        <= fb_addr;
			rowbase_q   <= ROW_W'(y_pos[5:3]) * ROW_W'(w_eff);
			rowbelow_q  <= ROW_W'(y_pos[5:3]) * ROW_W'(w_eff) + ROW_W'(w_eff);
			base_q      <= FA_W'(glyph_bytes_q) * FA_W'(char_code);
			rd_res_q    <= 8'd0;
			drawn_res_q <= (op_t'(op) == OP_DRAW) && !(char_code == 8'd0 && !back_color);
		end
		if (state_q == ST_FONT) begin
			drawn_res_q <= font_ok;
		end
		if (state_q == ST_PIX_WR) begin
			if (op_q == OP_READ) begin
				rd_res_q    <= fb_ok ? fb_rdata : 8'd0;
				drawn_res_q <= fb_ok;
			end else begin
				rd_res_q    <= (op_q == OP_GET && pix_ok) ?
					{7'd0, |(fb_rdata & bit_mask)} : 8'd0;
				drawn_res_q <= pix_ok;
			end
		end
		if (state_q == ST_G_RD1) begin
			glo_q <= font_rdata;
		end
		if (out_load) begin
			read_data_q <= rd_res_q;
			drawn_q     <= drawn_res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign drawn     = drawn_q;

	// framebuffer memory
	mpgb_ram #(
		.WIDTH(8),
		.DEPTH(FB_SIZE)
	) u_frame_ram (
		.clk  (clk),
		.we   (fb_we),
		.waddr(fb_waddr),
		.wdata(fb_wdata),
		.raddr(fb_raddr),
		.rdata(fb_rdata)
	);

	// font memory
	mpgb_ram #(
		.WIDTH(8),
		.DEPTH(FONT_BYTES)
	) u_font_ram (
		.clk  (clk),
		.we   (font_we),
		.waddr(font_waddr),
		.wdata(fbyte_q),
		.raddr(font_raddr),
		.rdata(font_rdata)
	);

endmodule

`default_nettype wire

### hw/rtl/mpgb_checker.sv
// port-level checker for the glyph blitter, bound to the top level
`default_nettype none

`include "mono_page_glyph_blitter_defines.svh"

module mpgb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cfg_we,
	input wire logic [2:0]  cfg_index,
	input wire logic [7:0]  cfg_data,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [2:0]  op,
	input wire logic [6:0]  x_pos,
	input wire logic [5:0]  y_pos,
	input wire logic        fore_color,
	input wire logic        back_color,
	input wire logic [7:0]  char_code,
	input wire logic [11:0] font_addr,
	input wire logic [7:0]  font_byte,
	input wire logic [9:0]  fb_addr,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  read_data,
	input wire logic        drawn
);

	// a stalled result keeps its payload
	`MPGB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(drawn), "result changed while stalled")

	// read data only comes from an access that counted
	`MPGB_ASSERT_NOW(a_read_drawn, clk, arst_n, out_valid, read_data == 8'd0 || drawn, "read data on a dropped command")

	// one command in work at a time
	`MPGB_ASSERT_NEXT(a_one_cmd, clk, arst_n, in_valid && in_ready, !in_ready, "second command taken while busy")

	// an idle block stays ready until a transaction arrives
	`MPGB_ASSERT_NEXT(a_idle_ready, clk, arst_n, in_ready && !in_valid, in_ready, "ready dropped without a transaction")

endmodule

bind mono_page_glyph_blitter mpgb_checker u_mpgb_checker (.*);

`default_nettype wire

### dv/tb.sv
// self-checking testbench for the glyph blitter: directed and random commands checked against a local model
module tb;
	import mpgb_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam logic [2:0]  OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0]  OP_SPARE_LAST  = 3'd7;

	typedef struct {
		logic [2:0]  op;
		logic [6:0]  x_pos;
		logic [5:0]  y_pos;
		logic        fore_color;
		logic        back_color;
		logic [7:0]  char_code;
		logic [11:0] font_addr;
		logic [7:0]  font_byte;
		logic [9:0]  fb_addr;
	} blit_cmd_t;

	typedef struct {
		logic [7:0] read_data;
		logic       drawn;
	} blit_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_LINE_WIDTH;
	logic [7:0]  cfg_data = 8'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  op = OP_FONT;
	logic [6:0]  x_pos = 7'd0;
	logic [5:0]  y_pos = 6'd0;
	logic        fore_color = 1'b0;
	logic        back_color = 1'b0;
	logic [7:0]  char_code = 8'd0;
	logic [11:0] font_addr = 12'd0;
	logic [7:0]  font_byte = 8'd0;
	logic [9:0]  fb_addr = 10'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  read_data;
	logic        drawn;

	mono_page_glyph_blitter u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.x_pos      (x_pos),
		.y_pos      (y_pos),
		.fore_color (fore_color),
		.back_color (back_color),
		.char_code  (char_code),
		.font_addr  (font_addr),
		.font_byte  (font_byte),
		.fb_addr    (fb_addr),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_data  (read_data),
		.drawn      (drawn)
	);

	// model of the block state and its registers
	bit   [7:0] frame_mem [FB_SIZE];
	bit   [7:0] font_mem [FONT_BYTES];
	bit         font_loaded [FONT_BYTES];
	logic [7:0] line_width   = 8'd128;
	logic [4:0] glyph_width  = 5'd8;
	logic [1:0] glyph_rows   = 2'd1;
	logic [4:0] glyph_height = 5'd8;
	logic [5:0] glyph_bytes  = 6'd8;

	blit_cmd_t    cmd_backlog [$];
	blit_result_t expected_results [$];
	blit_cmd_t    in_flight;
	int unsigned  accepted_count = 0;
	int unsigned  mismatch_count = 0;
	int unsigned  cycle_count = 0;

	// clock
	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int unsigned screen_width();
		return (line_width > MAX_COLUMNS) ? MAX_COLUMNS : line_width;
	endfunction

	function automatic int unsigned span_columns();
		return (glyph_width > GLYPH_MAX) ? GLYPH_MAX : glyph_width;
	endfunction

	function automatic int unsigned byte_rows();
		return (glyph_rows == 2'd0) ? 1 : ((glyph_rows > 2'd2) ? 2 : glyph_rows);
	endfunction

	// font store address of one byte of a glyph column, wrapping over the store
	function automatic int unsigned font_index(logic [7:0] code, int unsigned row,
			int unsigned col);
		return (glyph_bytes * code + row * span_columns() + col) % FONT_BYTES;
	endfunction

	// or/and one byte into the framebuffer, dropped off screen
	function automatic void merge_frame_byte(int unsigned pg, int unsigned col, logic [7:0] v,
			logic and_mode);
		int unsigned w;
		int unsigned a;
		w = screen_width();
		if (col >= w || pg >= PAGES)
			return;
		a = pg * w + col;
		if (a >= FB_SIZE)
			return;
		if (and_mode) begin
			frame_mem[a] &= v;
		end else begin
			frame_mem[a] |= v;
		end
	endfunction

	// glyph draw on the model framebuffer; returns the drawn flag
	function automatic logic render_glyph_model(blit_cmd_t c);
		int unsigned cols;
		int unsigned hgt;
		int unsigned rows;
		int unsigned pg;
		int unsigned s;
		logic [31:0] mask;
		logic [31:0] gcol;
		logic [31:0] colbits;
		logic        and_mode;
		if (c.char_code == 8'd0 && !c.back_color)
			return 1'b0;
		cols = span_columns();
		rows = byte_rows();
		hgt = (glyph_height > GLYPH_MAX) ? GLYPH_MAX : glyph_height;
		mask = (32'd1 << hgt) - 32'd1;
		pg = c.y_pos >> 3;
		s = c.y_pos[2:0];
		and_mode = !c.fore_color && !c.back_color;
		for (int unsigned ci = 0; ci < cols; ci++) begin
			gcol = 32'd0;
			for (int unsigned ri = 0; ri < rows; ri++)
				gcol |= {24'd0, font_mem[font_index(c.char_code, ri, ci)]} << (8 * ri);
			case ({c.fore_color, c.back_color})
				2'b10: colbits = gcol << s;
				2'b01: colbits = (~gcol & mask) << s;
				2'b11: colbits = mask << s;
				default: colbits = ~(mask << s);
			endcase
			merge_frame_byte(pg, c.x_pos + ci, colbits[7:0], and_mode);
			merge_frame_byte(pg + 1, c.x_pos + ci, colbits[15:8], and_mode);
		end
		return 1'b1;
	endfunction

	// apply one accepted command to the model and work out its result
	function automatic blit_result_t apply_blit_command(blit_cmd_t c);
		blit_result_t r;
		int unsigned  w;
		int unsigned  pg;
		int unsigned  a;
		logic [7:0]   bitm;
		r.read_data = 8'd0;
		r.drawn = 1'b0;
		w = screen_width();
		pg = c.y_pos >> 3;
		bitm = 8'd1 << c.y_pos[2:0];
		case (c.op)
			OP_FONT: begin
				font_mem[c.font_addr] = c.font_byte;
				r.drawn = 1'b1;
			end
			OP_SET, OP_GET: begin
				if (c.x_pos < w && pg < PAGES) begin
					a = pg * w + c.x_pos;
					if (c.op == OP_SET) begin
						if (c.fore_color) begin
							frame_mem[a] |= bitm;
						end else begin
							frame_mem[a] &= ~bitm;
						end
					end else begin
						r.read_data = ((frame_mem[a] & bitm) != 8'd0) ? 8'd1 : 8'd0;
					end
					r.drawn = 1'b1;
				end
			end
			OP_DRAW: r.drawn = render_glyph_model(c);
			OP_READ: begin
				if (c.fb_addr < FB_SIZE) begin
					r.read_data = frame_mem[c.fb_addr];
					r.drawn = 1'b1;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// idle percentage of each side, by how far the run has got
	function automatic int unsigned idle_pct(bit sender);
		if (accepted_count < 245)
			return sender ? 34 : 53;
		if (accepted_count < 490)
			return sender ? 53 : 34;
		return 0;
	endfunction

	function automatic blit_cmd_t make_cmd(logic [2:0] o, logic [6:0] x, logic [5:0] y,
			logic fc, logic bc, logic [7:0] code);
		blit_cmd_t c;
		c.op = o;
		c.x_pos = x;
		c.y_pos = y;
		c.fore_color = fc;
		c.back_color = bc;
		c.char_code = code;
		c.font_addr = 12'd0;
		c.font_byte = 8'd0;
		c.fb_addr = 10'd0;
		return c;
	endfunction

	// queue a command; a draw first gets loads for any font bytes it would read unwritten
	task automatic push_cmd(blit_cmd_t c);
		int unsigned a;
		if (c.op == OP_DRAW && !(c.char_code == 8'd0 && !c.back_color)) begin
			for (int unsigned ci = 0; ci < span_columns(); ci++)
				for (int unsigned ri = 0; ri < byte_rows(); ri++) begin
					a = font_index(c.char_code, ri, ci);
					if (!font_loaded[a])
						queue_font(a[11:0], 8'($urandom_range(0, 255)));
				end
		end
		if (c.op == OP_FONT)
			font_loaded[c.font_addr] = 1'b1;
		cmd_backlog.push_back(c);
	endtask

	task automatic queue_font(logic [11:0] addr, logic [7:0] data);
		blit_cmd_t c;
		c = make_cmd(OP_FONT, 7'd0, 6'd0, 1'b0, 1'b0, 8'd0);
		c.font_addr = addr;
		c.font_byte = data;
		push_cmd(c);
	endtask

	task automatic queue_read(logic [9:0] addr);
		blit_cmd_t c;
		c = make_cmd(OP_READ, 7'd0, 6'd0, 1'b0, 1'b0, 8'd0);
		c.fb_addr = addr;
		push_cmd(c);
	endtask

	// random command with every field random; draws reuse a few glyphs, one at the top code
	task automatic queue_random_item();
		blit_cmd_t   c;
		int unsigned k;
		c.x_pos = 7'($urandom_range(0, 127));
		c.y_pos = 6'($urandom_range(0, 63));
		c.fore_color = 1'($urandom_range(0, 1));
		c.back_color = 1'($urandom_range(0, 1));
		c.char_code = 8'($urandom_range(0, 255));
		c.font_addr = 12'($urandom_range(0, 4095));
		c.font_byte = 8'($urandom_range(0, 255));
		c.fb_addr = 10'($urandom_range(0, 1023));
		k = $urandom_range(0, 99);
		if (k < 8) begin
			c.op = OP_FONT;
		end else if (k < 23) begin
			c.op = OP_SET;
		end else if (k < 38) begin
			c.op = OP_GET;
		end else if (k < 53) begin
			c.op = OP_READ;
		end else if (k < 95) begin
			c.op = OP_DRAW;
			k = $urandom_range(0, 99);
			if (k < 80) begin
				c.char_code = 8'($urandom_range(0, 2));
			end else begin
				c.char_code = 8'd255;
			end
		end else begin
			c.op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		end
		push_cmd(c);
	endtask

	task automatic queue_random_items(int unsigned n);
		repeat (n) queue_random_item();
	endtask

	// register write, mirrored into the model
	task automatic set_register(cfg_reg_t idx, logic [7:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		case (idx)
			REG_LINE_WIDTH:   line_width = v;
			REG_GLYPH_WIDTH:  glyph_width = v[4:0];
			REG_GLYPH_ROWS:   glyph_rows = v[1:0];
			REG_GLYPH_HEIGHT: glyph_height = v[4:0];
			REG_GLYPH_BYTES:  glyph_bytes = v[5:0];
			default: ;
		endcase
	endtask

	task automatic program_layout(logic [7:0] lw, logic [7:0] gw, logic [7:0] rows,
			logic [7:0] ht, logic [7:0] stride);
		set_register(REG_LINE_WIDTH, lw);
		set_register(REG_GLYPH_WIDTH, gw);
		set_register(REG_GLYPH_ROWS, rows);
		set_register(REG_GLYPH_HEIGHT, ht);
		set_register(REG_GLYPH_BYTES, stride);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every queued command has been answered and the block has settled
	task automatic wait_drained();
		while (cmd_backlog.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic note_failure(string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	// command driver: holds each transaction until accepted, predicts on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(apply_blit_command(in_flight));
				accepted_count++;
			end
			if (!in_valid || in_ready) begin
				if (cmd_backlog.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
					in_flight = cmd_backlog.pop_front();
					in_valid <= 1'b1;
					op <= in_flight.op;
					x_pos <= in_flight.x_pos;
					y_pos <= in_flight.y_pos;
					fore_color <= in_flight.fore_color;
					back_color <= in_flight.back_color;
					char_code <= in_flight.char_code;
					font_addr <= in_flight.font_addr;
					font_byte <= in_flight.font_byte;
					fb_addr <= in_flight.fb_addr;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		blit_result_t exp_r;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					note_failure($sformatf("result with no transaction outstanding: %0h %0b",
						read_data, drawn));
				end else begin
					exp_r = expected_results.pop_front();
					if (read_data !== exp_r.read_data || drawn !== exp_r.drawn)
						note_failure($sformatf(
							"mismatch: expected read_data %0h drawn %0b, got read_data %0h drawn %0b",
							exp_r.read_data, exp_r.drawn, read_data, drawn));
				end
			end
			out_ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// stimulus sequence
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: default layout, one glyph with edge patterns
		queue_font(12'd8, 8'hFF);
		queue_font(12'd9, 8'h00);
		queue_font(12'd10, 8'h81);
		queue_font(12'd11, 8'h7E);
		queue_font(12'd12, 8'hA5);
		queue_font(12'd13, 8'h5A);
		queue_font(12'd14, 8'h01);
		queue_font(12'd15, 8'h80);
		queue_font(12'hFFF, 8'hFF);
		queue_read(10'd0);
		queue_read(10'd1023);
		push_cmd(make_cmd(OP_SET, 7'd0, 6'd0, 1'b1, 1'b0, 8'd0));
		push_cmd(make_cmd(OP_SET, 7'd127, 6'd63, 1'b1, 1'b0, 8'd0));
		push_cmd(make_cmd(OP_GET, 7'd0, 6'd0, 1'b0, 1'b0, 8'd0));
		push_cmd(make_cmd(OP_GET, 7'd127, 6'd63, 1'b0, 1'b0, 8'd0));
		push_cmd(make_cmd(OP_SET, 7'd127, 6'd63, 1'b0, 1'b0, 8'd0));
		push_cmd(make_cmd(OP_GET, 7'd127, 6'd63, 1'b0, 1'b0, 8'd0));
		// the four colour modes, a shifted draw and a draw off the bottom edge
		push_cmd(make_cmd(OP_DRAW, 7'd0, 6'd0, 1'b1, 1'b0, 8'd1));
		push_cmd(make_cmd(OP_DRAW, 7'd10, 6'd13, 1'b1, 1'b0, 8'd1));
		push_cmd(make_cmd(OP_DRAW, 7'd20, 6'd4, 1'b0, 1'b1, 8'd1));
		push_cmd(make_cmd(OP_DRAW, 7'd120, 6'd60, 1'b1, 1'b1, 8'd1));
		push_cmd(make_cmd(OP_DRAW, 7'd0, 6'd3, 1'b0, 1'b0, 8'd1));
		// code zero skipped on black, drawn on white
		push_cmd(make_cmd(OP_DRAW, 7'd40, 6'd0, 1'b1, 1'b0, 8'd0));
		push_cmd(make_cmd(OP_DRAW, 7'd40, 6'd8, 1'b0, 1'b1, 8'd0));
		queue_read(10'd0);
		queue_read(10'd266);
		queue_read(10'd1023);
		push_cmd(make_cmd(OP_GET, 7'd0, 6'd3, 1'b0, 1'b0, 8'd0));
		push_cmd(make_cmd(OP_SPARE_FIRST, 7'd127, 6'd63, 1'b1, 1'b1, 8'd255));
		push_cmd(make_cmd(OP_SPARE_LAST, 7'd0, 6'd0, 1'b0, 1'b0, 8'd0));
		queue_random_items(60);

		// widest glyphs, width above the screen limit
		wait_drained();
		program_layout(8'd255, 8'd16, 8'd2, 8'd16, 8'd32);
		queue_random_items(60);

		// smallest legal layout
		wait_drained();
		program_layout(8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
		queue_random_items(50);

		// all zero: no screen, empty glyphs
		wait_drained();
		program_layout(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		queue_random_items(30);

		// oversized width, height and rows, largest stride
		wait_drained();
		program_layout(8'd100, 8'd31, 8'd3, 8'd31, 8'd63);
		queue_random_items(60);

		// ordinary odd-sized font
		wait_drained();
		program_layout(8'd128, 8'd5, 8'd2, 8'd12, 8'd10);
		queue_random_items(60);

		// random register values
		wait_drained();
		program_layout(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
		queue_random_items(50);

		// back to the reset layout
		wait_drained();
		program_layout(8'd128, 8'd8, 8'd1, 8'd8, 8'd8);
		queue_random_items(50);

		wait_drained();
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
